// ===== rtl/skf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, types and microcode program of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int NOISE_W   = 24;
  localparam int GAIN_W    = 16;
  localparam int IDX_W     = 2;

  localparam int K_W    = FRAC_BITS;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int DEN_W  = NOISE_W + 1;
  localparam int REM_W  = NOISE_W + 2;
  localparam int DIFF_W = VAL_W + 1;
  localparam int PROD_W = K_W + 1 + DIFF_W;
  localparam int RND_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W  = RND_W + 1;
  localparam int COVP_W = K_W + 1 + NOISE_W;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int PC_W   = 3;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = NOISE_W'(1442);
  localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = NOISE_W'(40436);
  localparam logic [VAL_W-1:0]   INITIAL_ESTIMATE_RST  = '0;

  localparam logic [K_W:0]     ONE      = (K_W+1)'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF    = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(FRAC_BITS);

  typedef enum logic [IDX_W-1:0] {
    REG_PROCESS_NOISE     = 2'd0,
    REG_MEASUREMENT_NOISE = 2'd1,
    REG_INITIAL_ESTIMATE  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_DENOM, OP_DIV, OP_GAIN, OP_MUL, OP_RND, OP_WRITE
  } op_t;

  typedef enum logic [1:0] {WAIT_NONE, WAIT_IN, WAIT_OUT} wait_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_LOOP, JMP_START} jmp_t;

  typedef struct packed {
    op_t             op;
    wait_t           wt;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    logic fire;
    logic in_ready;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic cnt_nz;
  } stat_t;

  function automatic ucode_t prog_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, wt: WAIT_NONE, jmp: JMP_START, target: '0};
    unique case (pc)
      3'd0: w = '{op: OP_LOAD,  wt: WAIT_IN,   jmp: JMP_NEXT,  target: '0};
      3'd1: w = '{op: OP_DENOM, wt: WAIT_NONE, jmp: JMP_NEXT,  target: '0};
      3'd2: w = '{op: OP_DIV,   wt: WAIT_NONE, jmp: JMP_LOOP,  target: 3'd2};
      3'd3: w = '{op: OP_GAIN,  wt: WAIT_NONE, jmp: JMP_NEXT,  target: '0};
      3'd4: w = '{op: OP_MUL,   wt: WAIT_NONE, jmp: JMP_NEXT,  target: '0};
      3'd5: w = '{op: OP_RND,   wt: WAIT_NONE, jmp: JMP_NEXT,  target: '0};
      3'd6: w = '{op: OP_WRITE, wt: WAIT_OUT,  jmp: JMP_START, target: '0};
      default: w = '{op: OP_NOP, wt: WAIT_NONE, jmp: JMP_START, target: '0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/skf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_meas_if / skf_result_if
// Valid/ready channels for measurement items and result items.
// ----------------------------------------------------------------------------
interface skf_meas_if;
  logic                              valid;
  logic                              ready;
  logic signed [skf_pkg::VAL_W-1:0]  measurement;
  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [skf_pkg::VAL_W-1:0]   estimate;
  logic        [skf_pkg::NOISE_W-1:0] covariance;
  logic        [skf_pkg::GAIN_W-1:0]  gain;
  modport source (output valid, output estimate, output covariance, output gain,
                  input ready);
  modport sink   (input valid, input estimate, input covariance, input gain,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/skf_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_sequencer
// Step counter over the microcode ROM; handles waits and jumps.
// ----------------------------------------------------------------------------
module skf_sequencer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire skf_pkg::stat_t stat,
  output skf_pkg::ctl_t       ctl
);

  logic [skf_pkg::PC_W-1:0] pc;
  logic [skf_pkg::PC_W-1:0] pc_next;
  skf_pkg::ucode_t          uw;
  logic                     stall;

  always_comb begin
    uw = skf_pkg::prog_rom(pc);
    unique case (uw.wt)
      skf_pkg::WAIT_IN:  stall = !stat.in_valid;
      skf_pkg::WAIT_OUT: stall = stat.out_busy;
      default:           stall = 1'b0;
    endcase
    ctl.op       = uw.op;
    ctl.fire     = !stall;
    ctl.in_ready = (uw.wt == skf_pkg::WAIT_IN);
    if (stall) begin
      pc_next = pc;
    end else begin
      unique case (uw.jmp)
        skf_pkg::JMP_LOOP:  pc_next = stat.cnt_nz ? uw.target : pc + 1'b1;
        skf_pkg::JMP_START: pc_next = '0;
        default:            pc_next = pc + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/scalar_kalman_filter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// Scalar Kalman filter, constant-state model, fixed point, microcoded.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  meas     in   valid/ready      measurement (Q16.16 signed)
//  result   out  valid/ready      estimate, covariance (Q8.16), gain (Q0.16)
//  cfg      in   cfg_wr_en        cfg_index, cfg_data
//
//  The restoring divider for the gain runs one quotient bit per cycle over
//  FRAC_BITS + 1 steps.
//  The next item is accepted while a result waits in the output register;
//  the write step stalls only if that result has still not been taken.
//  Reset is synchronous and restores the register defaults, estimate 0,
//  covariance 0. Writing initial_estimate reloads the estimate, clears P.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  skf_meas_if.sink                           meas,
  skf_result_if.source                       result,
  input  wire logic                          cfg_wr_en,
  input  wire logic [skf_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [skf_pkg::VAL_W-1:0]     cfg_data
);

  localparam int F = skf_pkg::FRAC_BITS;
  localparam int NW = skf_pkg::NOISE_W;

  skf_pkg::ctl_t  ctl;
  skf_pkg::stat_t stat;

  logic [NW-1:0]                      process_noise;
  logic [NW-1:0]                      measurement_noise;
  logic signed [skf_pkg::VAL_W-1:0]   estimate_reg;
  logic [NW-1:0]                      error_covariance;

  logic signed [skf_pkg::VAL_W-1:0]   meas_r;
  logic [NW-1:0]                      ptemp;
  logic [skf_pkg::DEN_W-1:0]          denom;
  logic [skf_pkg::REM_W-1:0]          rem;
  logic [skf_pkg::QUO_W-1:0]          quo;
  logic [skf_pkg::CNT_W-1:0]          cnt;
  logic [skf_pkg::K_W-1:0]            k;
  logic signed [skf_pkg::DIFF_W-1:0]  diff;
  logic signed [skf_pkg::PROD_W-1:0]  prod;
  logic [skf_pkg::COVP_W-1:0]         covp;
  logic signed [skf_pkg::RND_W-1:0]   rnd;
  logic                               out_valid;

  logic [NW:0]                        pq_sum;
  logic [NW-1:0]                      ptemp_next;
  logic                               ge;
  logic [skf_pkg::REM_W-1:0]          rem_sub;
  logic [skf_pkg::K_W-1:0]            k_next;
  logic signed [skf_pkg::PROD_W-1:0]  prod_next;
  logic [skf_pkg::COVP_W-1:0]         covp_next;
  logic signed [skf_pkg::PROD_W-1:0]  rnd_sum;
  logic signed [skf_pkg::SUM_W-1:0]   est_sum;
  logic signed [skf_pkg::VAL_W-1:0]   est_next;
  logic [NW-1:0]                      cov_next;
  logic [F+skf_pkg::GAIN_W-1:0]       gain_wide;
  logic                               out_busy;

  skf_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  assign out_busy       = out_valid && !result.ready;
  assign stat.in_valid  = meas.valid;
  assign stat.out_busy  = out_busy;
  assign stat.cnt_nz    = (cnt != '0);
  assign meas.ready     = ctl.in_ready;
  assign result.valid   = out_valid;

  always_comb begin
    pq_sum     = {1'b0, error_covariance} + {1'b0, process_noise};
    ptemp_next = pq_sum[NW] ? '1 : pq_sum[NW-1:0];

    ge      = (rem >= {1'b0, denom});
    rem_sub = ge ? rem - {1'b0, denom} : rem;

    if (denom == '0) begin
      k_next = '0;
    end else if (quo[F]) begin
      k_next = '1;
    end else begin
      k_next = quo[F-1:0];
    end

    prod_next = $signed({1'b0, k}) * diff;
    covp_next = (skf_pkg::ONE - {1'b0, k}) * ptemp;
    rnd_sum   = prod + $signed(skf_pkg::HALF);

    est_sum = {{(skf_pkg::SUM_W-skf_pkg::VAL_W){estimate_reg[skf_pkg::VAL_W-1]}},
               estimate_reg} + {rnd[skf_pkg::RND_W-1], rnd};
    if (est_sum[skf_pkg::SUM_W-1:skf_pkg::VAL_W-1] == '0 ||
        est_sum[skf_pkg::SUM_W-1:skf_pkg::VAL_W-1] == '1) begin
      est_next = est_sum[skf_pkg::VAL_W-1:0];
    end else if (est_sum[skf_pkg::SUM_W-1]) begin
      est_next = {1'b1, {(skf_pkg::VAL_W-1){1'b0}}};
    end else begin
      est_next = {1'b0, {(skf_pkg::VAL_W-1){1'b1}}};
    end

    cov_next  = covp[F+NW-1:F];
    gain_wide = {k, {skf_pkg::GAIN_W{1'b0}}};
  end

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= skf_pkg::PROCESS_NOISE_RST;
      measurement_noise <= skf_pkg::MEASUREMENT_NOISE_RST;
      estimate_reg      <= skf_pkg::INITIAL_ESTIMATE_RST;
      error_covariance  <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.fire && ctl.op == skf_pkg::OP_WRITE) begin
        estimate_reg     <= est_next;
        error_covariance <= cov_next;
        out_valid        <= 1'b1;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          skf_pkg::REG_PROCESS_NOISE:     process_noise <= cfg_data[NW-1:0];
          skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data[NW-1:0];
          skf_pkg::REG_INITIAL_ESTIMATE: begin
            estimate_reg     <= cfg_data;
            error_covariance <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers driven by the microcode
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      unique case (ctl.op)
        skf_pkg::OP_LOAD: begin
          meas_r <= meas.measurement;
          ptemp  <= ptemp_next;
        end
        skf_pkg::OP_DENOM: begin
          denom <= {1'b0, ptemp} + {1'b0, measurement_noise};
          rem   <= {2'b00, ptemp};
          quo   <= '0;
          cnt   <= skf_pkg::DIV_STEPS;
        end
        skf_pkg::OP_DIV: begin
          rem <= {rem_sub[skf_pkg::REM_W-2:0], 1'b0};
          quo <= {quo[skf_pkg::QUO_W-2:0], ge};
          cnt <= cnt - 1'b1;
        end
        skf_pkg::OP_GAIN: begin
          k    <= k_next;
          diff <= {meas_r[skf_pkg::VAL_W-1], meas_r} -
                  {estimate_reg[skf_pkg::VAL_W-1], estimate_reg};
        end
        skf_pkg::OP_MUL: begin
          prod <= prod_next;
          covp <= covp_next;
        end
        skf_pkg::OP_RND: begin
          rnd <= rnd_sum[skf_pkg::PROD_W-1:F];
        end
        skf_pkg::OP_WRITE: begin
          result.estimate   <= est_next;
          result.covariance <= cov_next;
          result.gain       <= gain_wide[F+skf_pkg::GAIN_W-1:F];
        end
        default: ;
      endcase
    end
  end

  a_cov_shrinks: assert property (@(posedge clk) disable iff (rst)
    (ctl.fire && ctl.op == skf_pkg::OP_WRITE) |-> (cov_next <= ptemp))
    else $error("covariance grew past prediction");

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == skf_pkg::OP_GAIN && denom != '0) |-> (quo <= skf_pkg::ONE))
    else $error("gain quotient above one");

  a_valid_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.fire && ctl.op == skf_pkg::OP_WRITE))
    else $error("result valid without write step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctl.fire && ctl.op == skf_pkg::OP_WRITE) |-> !out_busy)
    else $error("result overwritten while waiting");

endmodule
`default_nettype wire
